/* src/nbc_pkg.sv */
// Package for the neighbor cache: action and result codes, entry type.
// No dependencies.
`default_nettype none
package nbc_pkg;
    localparam logic [1:0] ACT_LEARN  = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_SWEEP  = 2'd2;
    localparam logic [1:0] ACT_RESET  = 2'd3;

    localparam logic [2:0] KIND_LEARNED = 3'd0;
    localparam logic [2:0] KIND_FAILED  = 3'd1;
    localparam logic [2:0] KIND_LOOKUP  = 3'd2;
    localparam logic [2:0] KIND_PROBE   = 3'd3;
    localparam logic [2:0] KIND_SWEPT   = 3'd4;
    localparam logic [2:0] KIND_RESET   = 3'd5;

    typedef struct packed {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [47:0] mac;
        logic [15:0] gen;
        logic [31:0] seen;
    } entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        found;
        logic [47:0] mac;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } result_t;
endpackage
`default_nettype wire

/* src/nbc_mem.sv */
// Entry memory of the neighbor cache: one write port, one registered read port.
// Depends on nbc_pkg.
`default_nettype none
module nbc_mem #(
    parameter int ENTRIES = 32,
    parameter int AW = 5
) (
    input  wire logic           clk,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire nbc_pkg::entry_t wr_data,
    input  wire logic [AW-1:0]  rd_addr,
    output nbc_pkg::entry_t     rd_data
);
    nbc_pkg::entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

/* src/neighbor_cache_with_aging_unit.sv */
// Neighbor cache with aging: top level with control sequencer and flag bits.
// A lookup, failed learn or sweep scans every entry before its result; a learn that writes
// adds a write step, a generation reset answers as it is taken; output stalls extend a sweep.
// One request at a time: the next is taken at the edge that takes the final result.
// Reset (rst_n, async low) empties the table, zeroes generation and failure
// count, and sets idle_limit to 300.
`default_nettype none
module neighbor_cache_with_aging_unit #(
    parameter int ENTRIES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [63:0] addr_hi,
    input  wire logic [63:0] addr_lo,
    input  wire logic [47:0] mac_addr,
    input  wire logic [31:0] now,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic             found,
    output logic [47:0]      mac_out,
    output logic [63:0]      probe_hi,
    output logic [63:0]      probe_lo,
    output logic [31:0]      fail_total,
    output logic             last
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DONE = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        chk_reg, chk_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic [1:0]  act_reg;
    logic [63:0] hi_reg, lo_reg;
    logic [47:0] mac_reg;
    logic [31:0] now_reg;
    logic [31:0] idle_reg;
    logic [15:0] gen_reg;
    logic [31:0] fail_reg;
    logic [ENTRIES-1:0] valid_reg, mark_reg;
    logic        hit_reg, free_reg, match_reg;
    logic [AW-1:0] hit_idx_reg, free_idx_reg;
    logic [47:0] hit_mac_reg;
    logic [15:0] hit_gen_reg;
    logic        ov_reg;
    nbc_pkg::result_t res_reg;

    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    nbc_pkg::entry_t wr_data, rd_data;

    nbc_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    logic out_free;
    logic chk_go;
    logic [32:0] deadline;
    logic key_eq, idle;

    assign out_free = !ov_reg || out_ready;
    assign chk_go = chk_reg && out_free;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign cfg_ready = (state_reg == ST_IDLE);
    // hold the slot under check while a probe waits
    assign rd_addr = (state_reg == ST_SCAN && !out_free) ? chk_idx_reg : cnt_reg[AW-1:0];
    assign key_eq = valid_reg[chk_idx_reg] && rd_data.key_hi == hi_reg
                    && rd_data.key_lo == lo_reg;
    assign deadline = {1'b0, rd_data.seen} + {1'b0, idle_reg};
    assign idle = deadline < {1'b0, now_reg};

    assign out_valid = ov_reg;
    assign kind = res_reg.kind;
    assign found = res_reg.found;
    assign mac_out = res_reg.mac;
    assign probe_hi = res_reg.hi;
    assign probe_lo = res_reg.lo;
    assign last = res_reg.last;
    assign fail_total = fail_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        chk_next = 1'b0;
        chk_idx_next = cnt_reg[AW-1:0];
        wr_en = 1'b0;
        wr_addr = hit_idx_reg;
        wr_data.key_hi = hi_reg;
        wr_data.key_lo = lo_reg;
        wr_data.mac = mac_reg;
        wr_data.gen = gen_reg;
        wr_data.seen = now_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid && in_ready)
                begin
                    state_next = (action == nbc_pkg::ACT_RESET) ? ST_IDLE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (cnt_reg == CW'(ENTRIES))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        chk_next = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    chk_idx_next = chk_idx_reg;
                    cnt_next = cnt_reg;
                    chk_next = chk_reg;
                end
            end
            ST_DONE:
            begin
                if (act_reg == nbc_pkg::ACT_LEARN && (hit_reg || free_reg))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_WRITE:
            begin
                wr_en = 1'b1;
                wr_addr = hit_reg ? hit_idx_reg : free_idx_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            chk_reg <= 1'b0;
            idle_reg <= 32'd300;
            gen_reg <= '0;
            fail_reg <= '0;
            valid_reg <= '0;
            mark_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            chk_reg <= chk_next;
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                idle_reg <= cfg_data;
            end
            if (state_reg == ST_IDLE && in_valid && in_ready && action == nbc_pkg::ACT_RESET)
            begin
                gen_reg <= gen_reg + 16'd1;
                fail_reg <= '0;
                ov_reg <= 1'b1;
            end
            if (chk_go && act_reg == nbc_pkg::ACT_SWEEP && valid_reg[chk_idx_reg])
            begin
                if (rd_data.gen != gen_reg || (idle && mark_reg[chk_idx_reg]))
                begin
                    valid_reg[chk_idx_reg] <= 1'b0;
                    mark_reg[chk_idx_reg] <= 1'b0;
                end
                else if (idle)
                begin
                    mark_reg[chk_idx_reg] <= 1'b1;
                    ov_reg <= 1'b1;
                end
            end
            if (state_reg == ST_DONE && act_reg == nbc_pkg::ACT_LEARN
                && !hit_reg && !free_reg && fail_reg != '1)
            begin
                fail_reg <= fail_reg + 32'd1;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
                mark_reg[wr_addr] <= 1'b0;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                ov_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && in_ready)
        begin
            act_reg <= action;
            hi_reg <= addr_hi;
            lo_reg <= addr_lo;
            mac_reg <= mac_addr;
            now_reg <= now;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            match_reg <= 1'b0;
            res_reg <= '0;
            res_reg.kind <= nbc_pkg::KIND_RESET;
            res_reg.last <= 1'b1;
        end
        if (chk_go)
        begin
            if (act_reg != nbc_pkg::ACT_SWEEP)
            begin
                if (key_eq && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                    hit_idx_reg <= chk_idx_reg;
                    hit_mac_reg <= rd_data.mac;
                    hit_gen_reg <= rd_data.gen;
                end
                if (!valid_reg[chk_idx_reg] && !free_reg)
                begin
                    free_reg <= 1'b1;
                    free_idx_reg <= chk_idx_reg;
                end
            end
            else if (valid_reg[chk_idx_reg] && rd_data.gen == gen_reg && idle
                     && !mark_reg[chk_idx_reg])
            begin
                res_reg <= '0;
                res_reg.kind <= nbc_pkg::KIND_PROBE;
                res_reg.mac <= rd_data.mac;
                res_reg.hi <= rd_data.key_hi;
                res_reg.lo <= rd_data.key_lo;
            end
        end
        if (state_reg == ST_DONE)
        begin
            match_reg <= hit_reg && hit_gen_reg == gen_reg;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            res_reg <= '0;
            res_reg.last <= 1'b1;
            case (act_reg)
                nbc_pkg::ACT_LEARN:
                begin
                    res_reg.kind <= (hit_reg || free_reg) ? nbc_pkg::KIND_LEARNED
                                                          : nbc_pkg::KIND_FAILED;
                end
                nbc_pkg::ACT_LOOKUP:
                begin
                    res_reg.kind <= nbc_pkg::KIND_LOOKUP;
                    res_reg.found <= match_reg;
                    res_reg.mac <= match_reg ? hit_mac_reg : 48'd0;
                end
                default:
                begin
                    res_reg.kind <= nbc_pkg::KIND_SWEPT;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_idle_no_out_pend: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("request taken over a pending result");
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == ST_WRITE)
        else $error("memory written outside write step");
`endif
endmodule
`default_nettype wire
